// ----- hw/rtl/mts_pkg.sv -----
// ---------------------------------------------------------------------------
// mts_pkg: shared types and constants of the min tracking stack
// Stack depth, command and status codes, and the control struct that
// drives the row of stack cells.
// ---------------------------------------------------------------------------
package mts_pkg;

   // stack size and derived widths
   localparam int STACK_DEPTH = 128;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int RSP_COUNT_W = 8;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_READ = 2'd2
   } command_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_POP_EMPTY  = 2'd1,
      ST_PUSH_FULL  = 2'd2
   } status_type;

   // shift control broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctl_type;

endpackage

// ----- hw/rtl/mts_cell.sv -----
// ---------------------------------------------------------------------------
// mts_cell: one entry of the shifting stack
// Holds a value and the running minimum of itself and all entries below.
// A push loads the entry above, a pop loads the entry below.
// ---------------------------------------------------------------------------
module mts_cell
   import mts_pkg::*;
(
   input  logic                      clock,
   input  shift_ctl_type             ctl,
   input  logic signed [DATA_W-1:0]  upper_value,
   input  logic signed [DATA_W-1:0]  upper_min,
   input  logic signed [DATA_W-1:0]  lower_value,
   input  logic signed [DATA_W-1:0]  lower_min,
   output logic signed [DATA_W-1:0]  value_out,
   output logic signed [DATA_W-1:0]  min_out
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] min_ff, min_in;

   // select the neighbor that moves into this entry
   always_comb begin
      value_in = value_ff;
      min_in   = min_ff;
      if (ctl.push) begin
         value_in = upper_value;
         min_in   = upper_min;
      end else if (ctl.pop) begin
         value_in = lower_value;
         min_in   = lower_min;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      min_ff   <= min_in;
   end

   assign value_out = value_ff;
   assign min_out   = min_ff;

endmodule

// ----- hw/rtl/min_tracking_stack.sv -----
// ---------------------------------------------------------------------------
// min_tracking_stack: last-in first-out stack that reports its minimum
// The top of stack always sits in cell 0 of a row of shifting cells; each
// cell keeps its value and the minimum of the stack from there down.
// ---------------------------------------------------------------------------
// The result of a request is registered and appears in the cycle after its transfer.
// One request is accepted per cycle while the result register is not stalled; every
// cell shifts by one entry per cycle on a push or a pop.
// Reset clears the entry count and the result valid; cell contents are not
// cleared and are only read after a push has written them.
module min_tracking_stack
   import mts_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CMD_W-1:0]              req_command,
   input  logic signed [DATA_W-1:0]      req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_top_value,
   output logic signed [DATA_W-1:0]      rsp_min_value,
   output logic [RSP_COUNT_W-1:0]        rsp_count,
   output logic                          rsp_is_empty,
   output logic [STATUS_W-1:0]           rsp_status
);

   logic                     req_xfer;
   logic                     stack_empty;
   logic                     stack_full;
   shift_ctl_type            ctl;
   status_type               status;
   logic signed [DATA_W-1:0] push_min;

   logic [COUNT_W-1:0]       depth_ff, depth_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_min_in;
   logic [RSP_COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic signed [DATA_W-1:0] chain_value [STACK_DEPTH];
   logic signed [DATA_W-1:0] chain_min   [STACK_DEPTH];

   // request transfer when the result register is free or being drained
   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_xfer    = req_valid & ~req_stall;
   assign stack_empty = (depth_ff == '0);
   assign stack_full  = (depth_ff == COUNT_W'(STACK_DEPTH));

   // running minimum for a new top entry
   assign push_min = (!stack_empty && (chain_min[0] < req_value)) ? chain_min[0] : req_value;

   // decode command into shift control and status
   always_comb begin
      ctl    = '0;
      status = ST_OK;
      if (req_xfer) begin
         case (command_type'(req_command))
            CMD_PUSH: begin
               if (stack_full) status   = ST_PUSH_FULL;
               else            ctl.push = 1'b1;
            end
            CMD_POP: begin
               if (stack_empty) status  = ST_POP_EMPTY;
               else             ctl.pop = 1'b1;
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   // entry count
   always_comb begin
      depth_in = depth_ff;
      if (ctl.push)     depth_in = depth_ff + COUNT_W'(1);
      else if (ctl.pop) depth_in = depth_ff - COUNT_W'(1);
   end

   // row of stack cells, top of stack in cell 0
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] up_value, up_min, low_value, low_min;
      if (i == 0) begin : g_head
         assign up_value = req_value;
         assign up_min   = push_min;
      end else begin : g_mid
         assign up_value = chain_value[i-1];
         assign up_min   = chain_min[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign low_value = chain_value[i];
         assign low_min   = chain_min[i];
      end else begin : g_body
         assign low_value = chain_value[i+1];
         assign low_min   = chain_min[i+1];
      end
      mts_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .upper_value (up_value),
         .upper_min   (up_min),
         .lower_value (low_value),
         .lower_min   (low_min),
         .value_out   (chain_value[i]),
         .min_out     (chain_min[i])
      );
   end

   // result payload from the state after the operation
   always_comb begin
      rsp_top_ff_hold: begin
         rsp_top_in    = rsp_top_ff;
         rsp_min_in    = rsp_min_ff;
         rsp_count_in  = rsp_count_ff;
         rsp_empty_in  = rsp_empty_ff;
         rsp_status_in = rsp_status_ff;
      end
      if (req_xfer) begin
         rsp_count_in  = RSP_COUNT_W'(depth_in);
         rsp_empty_in  = (depth_in == '0);
         rsp_status_in = status;
         if (depth_in == '0) begin
            rsp_top_in = -32'sd1;
            rsp_min_in = '0;
         end else if (ctl.push) begin
            rsp_top_in = req_value;
            rsp_min_in = push_min;
         end else if (ctl.pop) begin
            rsp_top_in = chain_value[1];
            rsp_min_in = chain_min[1];
         end else begin
            rsp_top_in = chain_value[0];
            rsp_min_in = chain_min[0];
         end
      end
   end

   // result valid
   always_comb begin
      if (req_xfer)       rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_top_ff    <= rsp_top_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // entry count never exceeds the stack size
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= COUNT_W'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   // an accepted push puts its value on top of the next result
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      (ctl.push) |=> (rsp_valid && rsp_top_value == $past(req_value)))
      else $error("pushed value not on top");

   // reported minimum never exceeds the reported top
   a_min_le_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_empty) |-> (rsp_min_value <= rsp_top_value))
      else $error("minimum above top value");

   // entry count changes only on a push or a pop
   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      (!ctl.push && !ctl.pop) |=> $stable(depth_ff))
      else $error("entry count changed without push or pop");
`endif

endmodule
